@@ hw/rtl/hcbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Huffman code bit packer package
// Shared widths, request codes and the code table entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

    // Field widths
    localparam int BYTE_BITS    = 8;
    localparam int SYM_W        = 8;
    localparam int TABLE_DEPTH  = 256;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int REQ_W        = 2;
    localparam int PEND_W       = 7;
    localparam int PCNT_W       = 3;

    // Accumulator holds pending bits followed by one full code
    localparam int ACC_W        = PEND_W + CODE_W;
    localparam int TOT_W        = 6;

    localparam int DEF_MAX_CODE_LEN = 32;

    // Request kinds carried on tuser
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2,
        REQ_NONE   = 2'd3
    } hcbp_req_t;

    // One code table entry
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } hcbp_entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/hcbp_code_table.sv @@
// ----------------------------------------------------------------------------
// Huffman code table
// 256-entry code/length memory with a registered read. Per-entry
// valid bits, cleared at reset, make unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_code_table
    import hcbp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [SYM_W-1:0]  wr_addr,
    input  wire hcbp_entry_t       wr_entry,
    input  wire logic              rd_en,
    input  wire logic [SYM_W-1:0]  rd_addr,
    output hcbp_entry_t            rd_entry
);

    hcbp_entry_t                mem [TABLE_DEPTH];
    hcbp_entry_t                rd_data_reg;
    logic [TABLE_DEPTH-1:0]     valid_reg;
    logic                       rd_valid_reg;

    // Write and read the entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track written entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Unwritten entries read as an unused symbol
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

@@ hw/rtl/huffman_code_bit_packer.sv @@
// ----------------------------------------------------------------------------
// Huffman code bit packer
// Loads a symbol code table and packs looked-up codes MSB first into bytes.
// ----------------------------------------------------------------------------
// Handles one input item at a time. A load writes its table entry on transfer. An
// encode passes through the transfer, the registered code table read, then one emit
// step per completed byte (zero to four, since codes are at most 32 bits and at most
// seven bits are pending), each waiting while the output register is full; a flush
// with pending bits pads them into one byte and emits it.
// These steps follow from the registered table read and the single byte output
// register. The output register lets a finished byte wait while the next item
// is already taken. The table comes out of reset fully cleared (no sweep).
`default_nettype none

module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // symbol[7:0], code_bits[39:8], code_length[45:40]
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte[7:0]
    output logic             m_tlast
);

    localparam int LenCap = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [TOT_W-1:0]    total_reg, total_next;
    logic [PEND_W-1:0]   pbits_reg, pbits_next;
    logic [PCNT_W-1:0]   pcount_reg, pcount_next;
    logic                ovalid_reg, ovalid_next;
    logic [7:0]          obyte_reg, obyte_next;
    logic                olast_reg, olast_next;

    hcbp_req_t           req;
    logic [SYM_W-1:0]    symbol;
    logic [CODE_W-1:0]   code_bits;
    logic [LEN_W-1:0]    code_length;
    logic [LEN_W-1:0]    len_sat;
    logic                accept;
    logic                slot_free;
    hcbp_entry_t         wr_entry;
    hcbp_entry_t         rd_entry;
    logic [ACC_W-1:0]    joined;
    logic [TOT_W-1:0]    joined_total;
    logic [TOT_W-1:0]    total_less;
    logic [7:0]          padded;
    logic [PEND_W-1:0]   keep_mask;

    // Unpack input fields
    assign req         = hcbp_req_t'(s_tuser);
    assign symbol      = s_tdata[7:0];
    assign code_bits   = s_tdata[39:8];
    assign code_length = s_tdata[45:40];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !ovalid_reg || m_tready;

    // Saturate the length and drop code bits above it
    assign len_sat = (code_length > LEN_W'(LenCap)) ? LEN_W'(LenCap) : code_length;
    assign wr_entry.len  = len_sat;
    assign wr_entry.code = code_bits & ~({CODE_W{1'b1}} << len_sat);

    hcbp_code_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && (req == REQ_LOAD)),
        .wr_addr  (symbol),
        .wr_entry (wr_entry),
        .rd_en    (accept && (req == REQ_ENCODE)),
        .rd_addr  (symbol),
        .rd_entry (rd_entry)
    );

    // Append the looked-up code behind the pending bits
    assign joined       = (ACC_W'(pbits_reg) << rd_entry.len) | ACC_W'(rd_entry.code);
    assign joined_total = TOT_W'(pcount_reg) + rd_entry.len;

    // Byte extraction and leftover mask
    assign total_less = total_reg - TOT_W'(BYTE_BITS);
    assign keep_mask  = PEND_W'((8'd1 << total_less[PCNT_W-1:0]) - 8'd1);
    assign padded     = {1'b0, pbits_reg} << (4'd8 - {1'b0, pcount_reg});

    // Next-state logic
    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        total_next  = total_reg;
        pbits_next  = pbits_reg;
        pcount_next = pcount_reg;
        ovalid_next = ovalid_reg && !m_tready;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req)
                        REQ_ENCODE:
                        begin
                            state_next = ST_LOOKUP;
                        end
                        REQ_FLUSH:
                        begin
                            // Pad pending bits into one full byte
                            if (pcount_reg != '0)
                            begin
                                acc_next   = ACC_W'(padded);
                                total_next = TOT_W'(BYTE_BITS);
                                state_next = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
                if (rd_entry.len != '0)
                begin
                    if (joined_total >= TOT_W'(BYTE_BITS))
                    begin
                        acc_next   = joined;
                        total_next = joined_total;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        pbits_next  = joined[PEND_W-1:0];
                        pcount_next = joined_total[PCNT_W-1:0];
                    end
                end
            end
            ST_EMIT:
            begin
                // Hand out the oldest full byte when the output slot frees
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    obyte_next  = 8'(acc_reg >> total_less);
                    olast_next  = (total_less < TOT_W'(BYTE_BITS));
                    total_next  = total_less;
                    if (total_less < TOT_W'(BYTE_BITS))
                    begin
                        pcount_next = total_less[PCNT_W-1:0];
                        pbits_next  = acc_reg[PEND_W-1:0] & keep_mask;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pbits_reg  <= '0;
            pcount_reg <= '0;
            ovalid_reg <= 1'b0;
            acc_reg    <= '0;
            total_reg  <= '0;
            obyte_reg  <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pbits_reg  <= pbits_next;
            pcount_reg <= pcount_next;
            ovalid_reg <= ovalid_next;
            acc_reg    <= acc_next;
            total_reg  <= total_next;
            obyte_reg  <= obyte_next;
            olast_reg  <= olast_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = obyte_reg;
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

@@ tb/sv/huffman_code_bit_packer_tb.sv @@
// ----------------------------------------------------------------------------
// Huffman code bit packer testbench
// Streams load, encode and flush requests into the packer and checks every
// output byte and its tlast flag against a cycle-free model of the code table
// and the bit accumulator. A short directed run covers the corner cases, then
// random traffic runs in phases with different sender and receiver idling.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer_tb;

    import hcbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_CAP     = (DEF_MAX_CODE_LEN < CODE_W) ? DEF_MAX_CODE_LEN : CODE_W;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 112;
    localparam int MAX_REPORTS  = 10;

    // One request as it travels on the slave side
    typedef struct {
        hcbp_req_t         req;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } code_req_t;

    // One packed byte as it leaves on the master side
    typedef struct {
        logic [BYTE_BITS-1:0] data;
        logic                 last;
    } packed_byte_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tlast;

    // Stimulus and expectation stores
    code_req_t            req_q[$];
    code_req_t            drv_req;
    packed_byte_t         byte_q[$];
    logic [SYM_W-1:0]     loaded_syms[$];

    // Model state of the packer
    logic [CODE_W-1:0]    code_tab[TABLE_DEPTH];
    logic [LEN_W-1:0]     len_tab[TABLE_DEPTH];
    logic [PEND_W-1:0]    pend_bits;
    logic [PCNT_W-1:0]    pend_cnt;

    // Run control
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_stall_pct = 0;
    logic                 hold_arm = 1'b0;
    logic                 hold_done = 1'b0;
    int unsigned          hold_left = 0;
    int unsigned          cycle_cnt = 0;
    int unsigned          err_cnt = 0;
    int unsigned          bytes_checked = 0;
    int unsigned          n_loads = 0;
    int unsigned          n_encodes = 0;
    int unsigned          n_flushes = 0;
    int unsigned          n_ignored = 0;

    huffman_code_bit_packer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // symbol[7:0], code_bits[39:8], code_length[45:40]
        .s_tuser  (s_tuser),    // req_type[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // out_byte[7:0]
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // Apply one accepted request to the model and queue the bytes it yields
    task automatic pack_request(input code_req_t r);
        packed_byte_t b;
        logic [63:0]  acc;
        logic [63:0]  mask;
        int unsigned  ln;
        int unsigned  total;
        int unsigned  nbytes;
        case (r.req)
            REQ_LOAD:
            begin
                n_loads++;
                ln = (r.code_length > CODE_CAP) ? CODE_CAP : r.code_length;
                mask = (ln == 0) ? 64'd0 : ((64'd1 << ln) - 64'd1);
                code_tab[r.symbol] = CODE_W'(64'(r.code_bits) & mask);
                len_tab[r.symbol] = LEN_W'(ln);
            end
            REQ_ENCODE:
            begin
                n_encodes++;
                ln = len_tab[r.symbol];
                if (ln != 0)
                begin
                    acc = (64'(pend_bits) << ln) | 64'(code_tab[r.symbol]);
                    total = pend_cnt + ln;
                    nbytes = total / BYTE_BITS;
                    for (int k = 0; k < nbytes; k++)
                    begin
                        total -= BYTE_BITS;
                        b.data = BYTE_BITS'(acc >> total);
                        b.last = (k == nbytes - 1);
                        byte_q.push_back(b);
                    end
                    pend_cnt = PCNT_W'(total);
                    pend_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
                end
            end
            REQ_FLUSH:
            begin
                n_flushes++;
                if (pend_cnt != 0)
                begin
                    b.data = BYTE_BITS'(16'(pend_bits) << (BYTE_BITS - pend_cnt));
                    b.last = 1'b1;
                    byte_q.push_back(b);
                    pend_bits = '0;
                    pend_cnt = '0;
                end
            end
            default:
            begin
                n_ignored++;
            end
        endcase
    endtask

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic code_req_t make_req(hcbp_req_t req, int unsigned sym,
                                           logic [CODE_W-1:0] bits, int unsigned len);
        code_req_t r;
        r.req = req;
        r.symbol = SYM_W'(sym);
        r.code_bits = bits;
        r.code_length = LEN_W'(len);
        return r;
    endfunction

    // Table load with a length mostly short, sometimes long or oversized
    function automatic code_req_t rand_load();
        code_req_t   r;
        int unsigned pick;
        pick = $urandom_range(99);
        r = make_req(REQ_LOAD, $urandom_range(255), $urandom, 0);
        if (pick < 70)
            r.code_length = LEN_W'($urandom_range(1, 12));
        else if (pick < 88)
            r.code_length = LEN_W'($urandom_range(13, 32));
        else if (pick < 95)
            r.code_length = LEN_W'($urandom_range(33, 63));
        else
            r.code_length = '0;
        if (r.code_length != 0)
            loaded_syms.push_back(r.symbol);
        return r;
    endfunction

    // Mostly encodes of loaded symbols; some flushes, loads and noise
    function automatic code_req_t rand_req();
        code_req_t   r;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return rand_load();
        r = make_req(REQ_ENCODE, $urandom_range(255), $urandom, $urandom_range(63));
        if (pick < 18)
            r.req = REQ_FLUSH;
        else if (pick < 21)
            r.req = REQ_NONE;
        else if (pick < 92 && loaded_syms.size() > 0)
            r.symbol = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
        return r;
    endfunction

    // Driver: advance to the next request once the current one is taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                pack_request(drv_req);
            if (!s_tvalid || s_tready)
            begin
                if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_req = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {2'b00, drv_req.code_length, drv_req.code_bits,
                                drv_req.symbol};
                    s_tuser <= drv_req.req;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started once on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: check each byte transfer against the oldest expectation
    always @(posedge clk)
    begin
        packed_byte_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (byte_q.size() == 0)
                begin
                    flag_error($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
                end
                else
                begin
                    want = byte_q.pop_front();
                    bytes_checked++;
                    if (m_tdata !== want.data || m_tlast !== want.last)
                        flag_error($sformatf("byte exp %02h last %0b, got %02h last %0b",
                                             want.data, want.last, m_tdata, m_tlast));
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_cnt, byte_q.size());
            $display("huffman_code_bit_packer_tb failed");
            $finish;
        end
    end

    // Wait until every request is taken and every byte has come out
    task automatic wait_idle();
        while (req_q.size() != 0 || s_tvalid || byte_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int unsigned send_pct[4];
        int unsigned recv_pct[4];
        int unsigned counted;
        code_req_t   r;

        send_pct = '{0, 65, 0, 17};
        recv_pct = '{0, 0, 65, 17};
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            code_tab[i] = '0;
            len_tab[i] = '0;
        end
        pend_bits = '0;
        pend_cnt = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: unused symbol, empty flush, ignored kind, then table corners
        req_q.push_back(make_req(REQ_ENCODE, 5, 32'hFFFF_FFFF, 63));
        req_q.push_back(make_req(REQ_FLUSH, 255, 32'hFFFF_FFFF, 63));
        req_q.push_back(make_req(REQ_NONE, 255, 32'hFFFF_FFFF, 63));
        req_q.push_back(make_req(REQ_LOAD, 0, 32'hFFFF_FFFF, 32));
        req_q.push_back(make_req(REQ_LOAD, 255, 32'hA5A5_A5A5, 63));
        req_q.push_back(make_req(REQ_LOAD, 1, 32'hFFFF_FFFF, 1));
        req_q.push_back(make_req(REQ_LOAD, 2, 32'h0000_0000, 7));
        req_q.push_back(make_req(REQ_LOAD, 3, 32'h0000_FFFF, 0));
        req_q.push_back(make_req(REQ_LOAD, 4, 32'h5A5A_5A5A, 33));
        req_q.push_back(make_req(REQ_ENCODE, 1, 32'h0, 0));
        req_q.push_back(make_req(REQ_ENCODE, 0, 32'h0, 0));
        req_q.push_back(make_req(REQ_ENCODE, 2, 32'h0, 0));
        req_q.push_back(make_req(REQ_ENCODE, 255, 32'h0, 0));
        req_q.push_back(make_req(REQ_ENCODE, 3, 32'h0, 0));
        req_q.push_back(make_req(REQ_FLUSH, 0, 32'h0, 0));
        req_q.push_back(make_req(REQ_FLUSH, 0, 32'h0, 0));
        req_q.push_back(make_req(REQ_ENCODE, 2, 32'h0, 0));
        req_q.push_back(make_req(REQ_ENCODE, 1, 32'h0, 0));
        req_q.push_back(make_req(REQ_ENCODE, 4, 32'h0, 0));
        req_q.push_back(make_req(REQ_LOAD, 0, 32'h0000_0001, 0));
        req_q.push_back(make_req(REQ_ENCODE, 0, 32'h0, 0));
        req_q.push_back(make_req(REQ_ENCODE, 1, 32'h0, 0));
        req_q.push_back(make_req(REQ_FLUSH, 0, 32'h0, 0));
        wait_idle();

        // Random phases, each starting with a fresh batch of table loads
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pct[p];
            recv_stall_pct = recv_pct[p];
            loaded_syms.delete();
            for (int i = 0; i < 24; i++)
                req_q.push_back(rand_load());
            counted = 24;
            while (counted < PHASE_ITEMS)
            begin
                r = rand_req();
                req_q.push_back(r);
                if (r.req != REQ_NONE)
                    counted++;
            end
            // back up the output while the sender keeps offering
            if (p == 0)
                hold_arm = 1'b1;
            wait_idle();
        end

        $display("covered %0d loads, %0d encodes, %0d flushes, %0d ignored requests",
                 n_loads, n_encodes, n_flushes, n_ignored);
        $display("checked %0d output bytes over four idling phases, %0d errors",
                 bytes_checked, err_cnt);
        if (err_cnt == 0)
            $display("huffman_code_bit_packer_tb passed");
        else
            $display("huffman_code_bit_packer_tb failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_code_table.sv
hw/rtl/huffman_code_bit_packer.sv
tb/sv/huffman_code_bit_packer_tb.sv
